FILE: design/mandel_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the escape-time unit.
package mandel_pkg;

    // Field and register widths
    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS     = 28;
    localparam int PIXEL_BITS    = 12;
    localparam int ITER_BITS     = 17;
    localparam int ORIGIN_BITS   = 32;
    localparam int STEP_BITS     = 31;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS;
    localparam int PROD_W = 2 * MUL_W;
    localparam int EXT_W  = (ORIGIN_BITS > COORD_BITS) ? ORIGIN_BITS : COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [MUL_W-1:0]             mul_op_t;
    typedef logic [PROD_W-1:0]            prod_t;
    typedef logic [ITER_BITS-1:0]         iter_t;
    typedef logic [PIXEL_BITS-1:0]        pixel_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // |z|^2 escape threshold: 4.0, or the largest value if 4.0 does not fit
    localparam coord_t ESC_LIMIT = (FRAC_BITS + 2 >= COORD_BITS - 1) ? COORD_MAX
                                 : coord_t'(prod_t'(4) << FRAC_BITS);

    // Register reset values
    localparam iter_t                    RST_MAX_ITER  = ITER_BITS'(1000);
    localparam logic [ORIGIN_BITS-1:0]   RST_ORIGIN_RE = ORIGIN_BITS'(-603979776);
    localparam logic [ORIGIN_BITS-1:0]   RST_ORIGIN_IM = ORIGIN_BITS'(-352321536);
    localparam logic [STEP_BITS-1:0]     RST_STEP_RE   = STEP_BITS'(1174405);
    localparam logic [STEP_BITS-1:0]     RST_STEP_IM   = STEP_BITS'(1174405);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_RE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_IM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_IM   = 3'd4;

    // Saturating signed add
    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic signed [COORD_BITS:0] s;
        coord_t r;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        if (s[COORD_BITS] != s[COORD_BITS-1]) begin
            r = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
        end else begin
            r = s[COORD_BITS-1:0];
        end
        return r;
    endfunction

    // Product magnitude shifted down (FRAC_BITS, or FRAC_BITS-1 for the doubled
    // cross term), saturated to the coordinate range and given its sign
    function automatic coord_t sat_shift(input prod_t p, input logic neg, input logic half);
        prod_t m;
        prod_t bound;
        coord_t r;
        m     = half ? (p >> (FRAC_BITS - 1)) : (p >> FRAC_BITS);
        bound = neg ? (prod_t'(COORD_MAX) + prod_t'(1)) : prod_t'(COORD_MAX);
        if (m > bound) begin
            m = bound;
        end
        r = neg ? coord_t'(~m + prod_t'(1)) : coord_t'(m);
        return r;
    endfunction

    // Clamp a non-negative product to the coordinate range
    function automatic coord_t clamp_prod(input prod_t p);
        coord_t r;
        r = (p > prod_t'(COORD_MAX)) ? COORD_MAX : coord_t'(p);
        return r;
    endfunction

    // Clamp a signed origin register to the coordinate range
    function automatic coord_t clamp_origin(input logic signed [ORIGIN_BITS-1:0] o);
        logic signed [EXT_W-1:0] e;
        logic signed [EXT_W-1:0] emax;
        logic signed [EXT_W-1:0] emin;
        coord_t r;
        e    = o;
        emax = COORD_MAX;
        emin = COORD_MIN;
        if (e > emax) begin
            r = COORD_MAX;
        end else if (e < emin) begin
            r = COORD_MIN;
        end else begin
            r = coord_t'(e);
        end
        return r;
    endfunction

    // Magnitude of a coordinate as a multiplier operand
    function automatic mul_op_t mag_of(input coord_t v);
        logic [COORD_BITS-1:0] u;
        u = v[COORD_BITS-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
        return mul_op_t'(u);
    endfunction

endpackage

FILE: design/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit: pixel in, iteration count out, one shared multiplier.
//
// Input transfer (s_valid/s_ready) carries one pixel column and row. The pixel is
// mapped to c = origin + pixel * step in signed Q4.28 and z = z*z + c is iterated
// from zero until |z|^2 reaches 4.0 or the count reaches the iteration limit. One
// result transfer (m_valid/m_ready) returns the count with the pixel echoed.
// Timing: all products go through one 32x32 multiplier with a registered output.
// Setup runs through ST_CR, ST_CI and ST_C2 (the two c products), then each iteration
// runs through three product states, one escape test state and one update state.
// One item is in flight at a time: s_ready is high only while idle, so a stalled
// result (m_valid high, m_ready low) holds the unit until it is taken.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write only
// while idle. Unknown indexes are ignored.
// Reset (aresetn low, synchronous) returns to idle and loads the register defaults.
module mandelbrot_escape_time (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mandel_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mandel_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // Pixel input
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [mandel_pkg::PIXEL_BITS-1:0]       s_pixel_col,
    input  logic [mandel_pkg::PIXEL_BITS-1:0]       s_pixel_row,
    // Result output
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [mandel_pkg::ITER_BITS-1:0]        m_escape_count,
    output logic [mandel_pkg::PIXEL_BITS-1:0]       m_out_col,
    output logic [mandel_pkg::PIXEL_BITS-1:0]       m_out_row
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CR   = 4'd1;  // issue col * step_re
    localparam logic [3:0] ST_CI   = 4'd2;  // issue row * step_im, form cr
    localparam logic [3:0] ST_C2   = 4'd3;  // form ci
    localparam logic [3:0] ST_SQR  = 4'd4;  // issue zr * zr
    localparam logic [3:0] ST_SQI  = 4'd5;  // issue zi * zi, form zr^2
    localparam logic [3:0] ST_XY   = 4'd6;  // issue zr * zi, form zi^2
    localparam logic [3:0] ST_TEST = 4'd7;  // escape test, form 2*zr*zi
    localparam logic [3:0] ST_UPD  = 4'd8;  // z update, count
    localparam logic [3:0] ST_DONE = 4'd9;  // result waiting

    logic [3:0] state_reg, state_next;

    // Configuration registers
    mandel_pkg::iter_t                           max_iter_reg;
    logic signed [mandel_pkg::ORIGIN_BITS-1:0]   origin_re_reg;
    logic signed [mandel_pkg::ORIGIN_BITS-1:0]   origin_im_reg;
    logic [mandel_pkg::STEP_BITS-1:0]            step_re_reg;
    logic [mandel_pkg::STEP_BITS-1:0]            step_im_reg;

    // Working registers
    mandel_pkg::iter_t   count_reg, count_next;
    mandel_pkg::pixel_t  col_reg, col_next;
    mandel_pkg::pixel_t  row_reg, row_next;
    mandel_pkg::coord_t  zr_reg, zr_next;
    mandel_pkg::coord_t  zi_reg, zi_next;
    mandel_pkg::coord_t  cr_reg, cr_next;
    mandel_pkg::coord_t  ci_reg, ci_next;
    mandel_pkg::coord_t  zr2_reg, zr2_next;
    mandel_pkg::coord_t  zi2_reg, zi2_next;
    mandel_pkg::coord_t  xy_reg, xy_next;
    mandel_pkg::coord_t  diff_reg, diff_next;
    mandel_pkg::prod_t   prod_reg, prod_next;
    logic                prod_neg_reg, prod_neg_next;

    // Shared multiplier operands
    mandel_pkg::mul_op_t mul_a, mul_b;
    logic                mul_neg;

    mandel_pkg::coord_t  mag2;
    logic                escaped;
    mandel_pkg::iter_t   count_inc;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_DONE);
    assign m_escape_count = count_reg;
    assign m_out_col      = col_reg;
    assign m_out_row      = row_reg;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a   = mandel_pkg::mag_of(zr_reg);
        mul_b   = mandel_pkg::mag_of(zr_reg);
        mul_neg = 1'b0;
        unique case (state_reg)
            ST_CR: begin
                mul_a = mandel_pkg::mul_op_t'(col_reg);
                mul_b = mandel_pkg::mul_op_t'(step_re_reg);
            end
            ST_CI: begin
                mul_a = mandel_pkg::mul_op_t'(row_reg);
                mul_b = mandel_pkg::mul_op_t'(step_im_reg);
            end
            ST_SQI: begin
                mul_a = mandel_pkg::mag_of(zi_reg);
                mul_b = mandel_pkg::mag_of(zi_reg);
            end
            ST_XY: begin
                mul_b   = mandel_pkg::mag_of(zi_reg);
                mul_neg = zr_reg[mandel_pkg::COORD_BITS-1] ^ zi_reg[mandel_pkg::COORD_BITS-1];
            end
            default: begin
            end
        endcase
        prod_next     = mandel_pkg::prod_t'(mul_a) * mandel_pkg::prod_t'(mul_b);
        prod_neg_next = mul_neg;
    end

    // Escape test on the stored squares
    assign mag2      = mandel_pkg::sat_add(zr2_reg, zi2_reg);
    assign escaped   = (mag2 >= mandel_pkg::ESC_LIMIT);
    assign count_inc = count_reg + mandel_pkg::iter_t'(1);

    // Sequencer and datapath next values
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr2_next   = zr2_reg;
        zi2_next   = zi2_reg;
        xy_next    = xy_reg;
        diff_next  = diff_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    col_next   = s_pixel_col;
                    row_next   = s_pixel_row;
                    count_next = '0;
                    zr_next    = '0;
                    zi_next    = '0;
                    state_next = (max_iter_reg == '0) ? ST_DONE : ST_CR;
                end
            end
            ST_CR: begin
                state_next = ST_CI;
            end
            ST_CI: begin
                cr_next    = mandel_pkg::sat_add(mandel_pkg::clamp_origin(origin_re_reg),
                                                 mandel_pkg::clamp_prod(prod_reg));
                state_next = ST_C2;
            end
            ST_C2: begin
                ci_next    = mandel_pkg::sat_add(mandel_pkg::clamp_origin(origin_im_reg),
                                                 mandel_pkg::clamp_prod(prod_reg));
                state_next = ST_SQR;
            end
            ST_SQR: begin
                state_next = ST_SQI;
            end
            ST_SQI: begin
                zr2_next   = mandel_pkg::sat_shift(prod_reg, prod_neg_reg, 1'b0);
                state_next = ST_XY;
            end
            ST_XY: begin
                zi2_next   = mandel_pkg::sat_shift(prod_reg, prod_neg_reg, 1'b0);
                state_next = ST_TEST;
            end
            ST_TEST: begin
                xy_next    = mandel_pkg::sat_shift(prod_reg, prod_neg_reg, 1'b1);
                diff_next  = mandel_pkg::sat_add(zr2_reg, -zi2_reg);
                state_next = escaped ? ST_DONE : ST_UPD;
            end
            ST_UPD: begin
                zr_next    = mandel_pkg::sat_add(diff_reg, cr_reg);
                zi_next    = mandel_pkg::sat_add(xy_reg, ci_reg);
                count_next = count_inc;
                state_next = (count_inc == max_iter_reg) ? ST_DONE : ST_SQR;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_iter_reg  <= mandel_pkg::RST_MAX_ITER;
            origin_re_reg <= mandel_pkg::RST_ORIGIN_RE;
            origin_im_reg <= mandel_pkg::RST_ORIGIN_IM;
            step_re_reg   <= mandel_pkg::RST_STEP_RE;
            step_im_reg   <= mandel_pkg::RST_STEP_IM;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    mandel_pkg::CFG_MAX_ITER:
                        max_iter_reg  <= cfg_data[mandel_pkg::ITER_BITS-1:0];
                    mandel_pkg::CFG_ORIGIN_RE:
                        origin_re_reg <= cfg_data[mandel_pkg::ORIGIN_BITS-1:0];
                    mandel_pkg::CFG_ORIGIN_IM:
                        origin_im_reg <= cfg_data[mandel_pkg::ORIGIN_BITS-1:0];
                    mandel_pkg::CFG_STEP_RE:
                        step_re_reg   <= cfg_data[mandel_pkg::STEP_BITS-1:0];
                    mandel_pkg::CFG_STEP_IM:
                        step_im_reg   <= cfg_data[mandel_pkg::STEP_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        zr_reg       <= zr_next;
        zi_reg       <= zi_next;
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        zr2_reg      <= zr2_next;
        zi2_reg      <= zi2_next;
        xy_reg       <= xy_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
    end

endmodule
